// ----- rtl/core/first_fit_conflict_grouping_defines.svh -----
// ----------------------------------------------------------------------------
// first fit conflict grouping assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_CONFLICT_GROUPING_DEFINES_SVH
`define FIRST_FIT_CONFLICT_GROUPING_DEFINES_SVH

// property checked outside reset
`define FFCG_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("ffcg assertion failed");

// property checked on every edge, reset included
`define FFCG_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("ffcg assertion failed");

`endif

// ----- rtl/core/ffcg_pkg.sv -----
// ----------------------------------------------------------------------------
// ffcg_pkg
// shared widths and the token that travels along the group cell chain
// ----------------------------------------------------------------------------
`default_nettype none

package ffcg_pkg;

   // capacity of one set, also the number of group cells
   localparam int MAX_SEGMENTS = 64;
   localparam int NUM_CELLS    = MAX_SEGMENTS;

   // fixed field widths
   localparam int ROW_W     = 64;
   localparam int SEG_W     = 6;
   localparam int SEG_NUM_W = 7;
   localparam int GROUP_W   = 6;
   localparam int RSP_W     = 16;

   // one row moving through the chain
   typedef struct packed {
      logic               valid;
      logic               first;
      logic [ROW_W-1:0]   row;
      logic [SEG_W-1:0]   seg;
      logic               too_many;
      logic               placed;
      logic [GROUP_W-1:0] group;
      logic               opened;
   } token_type;

endpackage

`default_nettype wire

// ----- rtl/core/ffcg_cell.sv -----
// ----------------------------------------------------------------------------
// ffcg_cell
// one group: holds its member mask, claims a passing row that fits or opens
// ----------------------------------------------------------------------------
`default_nettype none

module ffcg_cell (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        advance,
   input  wire logic [ffcg_pkg::GROUP_W-1:0] cell_id,
   input  wire ffcg_pkg::token_type         tok_in,
   output ffcg_pkg::token_type              tok_out
);

   logic [ffcg_pkg::ROW_W-1:0] members_ff, members_in, cur_members;
   logic                       open_ff, open_in, cur_open;
   ffcg_pkg::token_type        tok_ff, tok_in_next;
   logic                       clear, fits, claim;

   // a set start wipes this group as the row passes by
   assign clear       = tok_in.valid & tok_in.first;
   assign cur_members = clear ? '0 : members_ff;
   assign cur_open    = clear ? 1'b0 : open_ff;

   // first fit: open group with no conflict, or the first closed group
   assign fits  = cur_open & ((cur_members & tok_in.row) == '0);
   assign claim = tok_in.valid & ~tok_in.too_many & ~tok_in.placed & (fits | ~cur_open);

   // group state update
   always_comb begin
      members_in = members_ff;
      open_in    = open_ff;
      if (advance && tok_in.valid) begin
         open_in    = cur_open | claim;
         members_in = cur_members;
         if (claim) begin
            if (cur_open) begin
               members_in = cur_members | (ffcg_pkg::ROW_W'(1) << tok_in.seg);
            end else begin
               members_in = ffcg_pkg::ROW_W'(1) << tok_in.seg;
            end
         end
      end
   end

   // token handed to the next cell
   always_comb begin
      tok_in_next = tok_in;
      if (claim) begin
         tok_in_next.placed = 1'b1;
         tok_in_next.group  = cell_id;
         tok_in_next.opened = ~cur_open;
      end
   end

   // group and token registers, only the open bit and token valid are reset
   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff      <= 1'b0;
         tok_ff.valid <= 1'b0;
      end else begin
         open_ff <= open_in;
         if (advance) begin
            tok_ff.valid <= tok_in_next.valid;
         end
      end
      members_ff <= members_in;
      if (advance) begin
         tok_ff.first    <= tok_in_next.first;
         tok_ff.row      <= tok_in_next.row;
         tok_ff.seg      <= tok_in_next.seg;
         tok_ff.too_many <= tok_in_next.too_many;
         tok_ff.placed   <= tok_in_next.placed;
         tok_ff.group    <= tok_in_next.group;
         tok_ff.opened   <= tok_in_next.opened;
      end
   end

   assign tok_out = tok_ff;

endmodule

`default_nettype wire

// ----- rtl/core/first_fit_conflict_grouping.sv -----
// each row passes the registers of the 64 group cells and then the output register
// throughput: one row per cycle while the chain is not stalled; each row steps one group cell per cycle down the chain
// the whole chain stalls together while a result waits on rsp_tready
// reset clears all group open bits, the segment counter, the token valid bits and the result valid flag;
// no clearing pass, the block takes a row in the first cycle after reset
// ----------------------------------------------------------------------------
// first_fit_conflict_grouping
// greedy first fit grouping of overlapping segments over a chain of group cells
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_conflict_grouping (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output      logic                          req_tready,
   input  wire logic [ffcg_pkg::ROW_W-1:0]    req_tdata,  // [63:0] overlap_row
   input  wire logic                          req_tuser,  // [0] first_of_set
   output      logic                          rsp_tvalid,
   input  wire logic                          rsp_tready,
   output      logic [ffcg_pkg::RSP_W-1:0]    rsp_tdata   // [6:0] segment_number,
                                                          // [12:7] group_index,
                                                          // [13] opened_group,
                                                          // [14] too_many, [15] zero
);

   logic                           advance;
   logic [ffcg_pkg::SEG_NUM_W-1:0] seen_ff, seen_in, seen_cur;
   logic                           too_many_entry;
   ffcg_pkg::token_type            chain [0:ffcg_pkg::NUM_CELLS];
   ffcg_pkg::token_type            last_tok;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [ffcg_pkg::RSP_W-1:0]     rsp_data_ff, rsp_data_in;
   logic [ffcg_pkg::SEG_NUM_W-1:0] seg_number;

   // whole chain moves when the output register can take a result
   assign advance    = ~rsp_valid_ff | rsp_tready;
   assign req_tready = advance;

   // segment numbering at entry
   assign seen_cur       = req_tuser ? '0 : seen_ff;
   assign too_many_entry = seen_cur >= ffcg_pkg::SEG_NUM_W'(ffcg_pkg::MAX_SEGMENTS);

   always_comb begin
      seen_in = seen_ff;
      if (req_tvalid && advance) begin
         seen_in = too_many_entry ? seen_cur : seen_cur + 1'b1;
      end
   end

   // token entering the first cell
   always_comb begin
      chain[0].valid    = req_tvalid;
      chain[0].first    = req_tuser;
      chain[0].row      = req_tdata;
      chain[0].seg      = seen_cur[ffcg_pkg::SEG_W-1:0];
      chain[0].too_many = too_many_entry;
      chain[0].placed   = 1'b0;
      chain[0].group    = '0;
      chain[0].opened   = 1'b0;
   end

   // chain of group cells
   for (genvar g = 0; g < ffcg_pkg::NUM_CELLS; g++) begin : g_cell
      ffcg_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .cell_id (ffcg_pkg::GROUP_W'(g)),
         .tok_in  (chain[g]),
         .tok_out (chain[g+1])
      );
   end

   assign last_tok = chain[ffcg_pkg::NUM_CELLS];

   // result formatting
   assign seg_number = last_tok.too_many ? '0 : {1'b0, last_tok.seg} + 1'b1;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         rsp_valid_in = last_tok.valid;
         rsp_data_in  = {1'b0, last_tok.too_many, last_tok.opened, last_tok.group, seg_number};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

// ----- rtl/core/ffcg_checker.sv -----
// ----------------------------------------------------------------------------
// ffcg_checker
// port level checks on the grouping block, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "first_fit_conflict_grouping_defines.svh"

module ffcg_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata
);

   // a stalled result holds
   `FFCG_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))

   // a dropped row reports nothing but the drop flag
   `FFCG_ASSERT(a_drop_clean, clock, reset, rsp_tvalid && rsp_tdata[14] |-> rsp_tdata[13:0] == 14'd0)

   // a placed segment never lands in a group beyond its own number
   `FFCG_ASSERT(a_group_bound, clock, reset, rsp_tvalid && !rsp_tdata[14] |-> rsp_tdata[6:0] != 7'd0 && {1'b0, rsp_tdata[12:7]} < rsp_tdata[6:0])

   // first segment of a set always opens group zero
   `FFCG_ASSERT(a_first_opens, clock, reset, rsp_tvalid && !rsp_tdata[14] && rsp_tdata[6:0] == 7'd1 |-> rsp_tdata[13] && rsp_tdata[12:7] == 6'd0)

   // no result right after reset
   `FFCG_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_tvalid)

endmodule

bind first_fit_conflict_grouping ffcg_checker u_ffcg_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
